@@ rtl/wsac_pkg.sv @@
`default_nettype none

package wsac_pkg;

    // Correction table: speed in whole units, corrections in tenths at 0/90/180 degrees
    localparam int TABLE_ROWS = 29;
    localparam int ROW_W      = $clog2(TABLE_ROWS);
    localparam int SPD_W      = 10;
    localparam int COEF_W     = 8;

    localparam logic [SPD_W-1:0] ROW_SPEED [TABLE_ROWS] = '{
        0, 20, 25, 30, 35, 40, 45, 50, 55, 60, 65, 70, 75, 80, 85,
        90, 95, 100, 105, 110, 115, 120, 125, 130, 135, 140, 145, 150, 999
    };
    localparam logic signed [COEF_W-1:0] ROW_C0 [TABLE_ROWS] = '{
        0, 33, 35, 38, 42, 45, 47, 50, 53, 57, 58, 62, 64, 68, 71,
        74, 75, 77, 82, 85, 89, 95, 100, 98, 98, 93, 95, 98, 98
    };
    localparam logic signed [COEF_W-1:0] ROW_C90 [TABLE_ROWS] = '{
        0, -23, -27, -29, -34, -41, -38, -45, -48, -53, -60, -56, -60, -64, -74,
        -80, -81, -79, -81, -85, -88, -94, -96, -98, -100, -102, -109, -121, -121
    };
    localparam logic signed [COEF_W-1:0] ROW_C180 [TABLE_ROWS] = '{
        0, -36, -46, -48, -53, -57, -45, -49, -52, -59, -60, -61, -68, -69, -68,
        -68, -75, -72, -77, -77, -85, -90, -98, -103, -110, -113, -105, -120, -120
    };

    // Field widths
    localparam int RAW_W  = 14;
    localparam int ANG_W  = 12;
    localparam int FANG_W = 11;  // folded angle, 0..1800
    localparam int OUT_W  = 15;

    // Angle constants in tenths of a degree
    localparam int ANG_FULL  = 3600;
    localparam int ANG_HALF  = 1800;
    localparam int ANG_QUART = 900;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Classified sample handed from front to back
    typedef struct packed {
        logic [RAW_W-1:0]  raw;
        logic [FANG_W-1:0] ang;
        logic [ROW_W-1:0]  hi;
    } entry_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic   valid;
        entry_t data;
    } q_head_t;

endpackage

`default_nettype wire

@@ rtl/wind_speed_angle_correction.sv @@
// Wind speed correction by bilinear interpolation over a constant table.
// Input channel (in_valid/in_ready): raw_speed in 1/16 units and wind_angle
// in tenths of a degree. Output channel (out_valid/out_ready): one
// corrected_speed per input transaction, in 1/16 units, rounded to nearest
// and saturated to 0..32767, delivered in input order.
// Throughput: one transaction per cycle while the receiver keeps out_ready high,
// set by the combinational front end (angle fold plus parallel row compares)
// and a fully pipelined back end. Path from input acceptance to out_valid:
// the queue, 3 arithmetic stages, 9 radix-2 divider stages, output register.
// A two-entry queue parts the front end from the back-end pipeline. When the
// receiver holds out_ready low the back end freezes as a whole; the queue
// keeps taking input until it fills, then in_ready drops.
// Reset (rst_n, asynchronous, active low) empties the queue and clears all
// pipeline valid flags; no table or memory needs initializing.
`default_nettype none

module wind_speed_angle_correction
    import wsac_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [RAW_W-1:0]  raw_speed,
    input  wire logic [ANG_W-1:0]  wind_angle,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [OUT_W-1:0]       corrected_speed
);

    logic    q_full;
    logic    push;
    entry_t  push_data;
    logic    pop;
    q_head_t head;

    wsac_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_speed  (raw_speed),
        .wind_angle (wind_angle),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    wsac_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head)
    );

    wsac_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .corrected_speed (corrected_speed)
    );

endmodule

`default_nettype wire

@@ rtl/wsac_front.sv @@
`default_nettype none

module wsac_front
    import wsac_pkg::*;
(
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [RAW_W-1:0]  raw_speed,
    input  wire logic [ANG_W-1:0]  wind_angle,
    input  wire logic              q_full,
    output logic                   push,
    output entry_t                 push_data
);

    logic [ANG_W-1:0]      ang_wrap;
    logic [ANG_W-1:0]      ang_fold;
    logic [TABLE_ROWS-1:0] above;
    logic [ROW_W-1:0]      hi_idx;

    // Handshake: take a transaction whenever the queue has room
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // Angle wrap and fold onto 0..180 degrees
    always_comb
    begin
        if (wind_angle >= ANG_W'(ANG_FULL))
            ang_wrap = wind_angle - ANG_W'(ANG_FULL);
        else
            ang_wrap = wind_angle;
        if (ang_wrap > ANG_W'(ANG_HALF))
            ang_fold = ANG_W'(ANG_FULL) - ang_wrap;
        else
            ang_fold = ang_wrap;
    end

    // Bracket search: parallel compares against every row speed
    always_comb
    begin
        for (int i = 0; i < TABLE_ROWS; i++)
            above[i] = raw_speed > {ROW_SPEED[i], 4'b0000};
    end

    // Speeds rise monotonically, so the upper row is where 'above' first drops
    always_comb
    begin
        hi_idx = '0;
        if (!above[0])
            hi_idx = '0;
        for (int i = 1; i < TABLE_ROWS; i++)
            if (above[i-1] && !above[i])
                hi_idx = hi_idx | ROW_W'(i);
        if (above[TABLE_ROWS-1])
            hi_idx = ROW_W'(TABLE_ROWS - 1);
    end

    always_comb
    begin
        push_data.raw = raw_speed;
        push_data.ang = ang_fold[FANG_W-1:0];
        push_data.hi  = hi_idx;
    end

endmodule

`default_nettype wire

@@ rtl/wsac_queue.sv @@
`default_nettype none

module wsac_queue
    import wsac_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_data,
    output logic        full,
    input  wire logic   pop,
    output q_head_t     head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = count_reg != '0;
    assign head.data  = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

@@ rtl/wsac_back.sv @@
`default_nettype none

module wsac_back
    import wsac_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire q_head_t           head,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [OUT_W-1:0]       corrected_speed
);

    // Fixed-point layout
    localparam int CORR_W   = 18;               // row correction x900, tenths
    localparam int PROD_W   = CORR_W + 2;
    localparam int SLOPE_W  = COEF_W + 1;
    localparam int X_W      = 10;               // angle within a segment, 0..900
    localparam int DC_W     = CORR_W + 1;
    localparam int OFS_W    = RAW_W;
    localparam int P1_W     = CORR_W + SPD_W;   // cl * ds
    localparam int C2_W     = DC_W + OFS_W + 1; // (ch - cl) * offset
    localparam int DIV_BITS = 9;                // quotient carries a bias of 2^(DIV_BITS-1)
    localparam int DEN_STEP = 9000;
    localparam int DVS_STEP = 2 * DEN_STEP;
    localparam int BIAS_STEP = (2 * (1 << (DIV_BITS - 1)) + 1) * DEN_STEP;
    localparam int DVS_W    = 24;
    localparam int K_W      = 32;
    localparam int SUM_W    = 36;
    localparam int REM_W    = 34;
    localparam int RES_W    = RAW_W + 3;

    logic adv;

    // Stage 1: row corrections, spacing and offset
    logic                     s1_v_reg;
    logic [RAW_W-1:0]         s1_raw_reg;
    logic signed [CORR_W-1:0] s1_cl_reg, s1_ch_reg;
    logic [SPD_W-1:0]         s1_ds_reg;
    logic [OFS_W-1:0]         s1_ofs_reg;

    // Stage 2: products
    logic                     s2_v_reg;
    logic [RAW_W-1:0]         s2_raw_reg;
    logic signed [P1_W-1:0]   s2_p1_reg;
    logic signed [C2_W-1:0]   s2_c2_reg;
    logic [DVS_W-1:0]         s2_dvs_reg;
    logic [K_W-1:0]           s2_k_reg;

    // Stage 3: biased dividend
    logic                     s3_v_reg;
    logic [RAW_W-1:0]         s3_raw_reg;
    logic [REM_W-1:0]         s3_rem_reg;
    logic [DVS_W-1:0]         s3_dvs_reg;

    // Division steps, one quotient bit each
    logic                     dv_v_reg   [DIV_BITS];
    logic [RAW_W-1:0]         dv_raw_reg [DIV_BITS];
    logic [REM_W-1:0]         dv_rem_reg [DIV_BITS];
    logic [DVS_W-1:0]         dv_dvs_reg [DIV_BITS];
    logic [DIV_BITS-1:0]      dv_quo_reg [DIV_BITS];
    logic [REM_W-1:0]         dv_rem_next [DIV_BITS];
    logic [DIV_BITS-1:0]      dv_quo_next [DIV_BITS];

    // Output register
    logic                     out_v_reg;
    logic [OUT_W-1:0]         out_data_reg, out_data_next;

    logic [ROW_W-1:0]         lo_idx;
    logic                     seg_hi;
    logic [X_W-1:0]           seg_x;
    logic signed [CORR_W-1:0] cl_next, ch_next;
    logic [SPD_W-1:0]         ds_next;
    logic [OFS_W-1:0]         ofs_next;
    logic signed [P1_W-1:0]   p1_next;
    logic signed [C2_W-1:0]   c2_next;
    logic [DVS_W-1:0]         dvs_next;
    logic [K_W-1:0]           k_next;
    logic [REM_W-1:0]         rem_next;

    // Whole pipeline moves unless the result register is full and stalled
    assign adv             = !out_v_reg || out_ready;
    assign pop             = adv && head.valid;
    assign out_valid       = out_v_reg;
    assign corrected_speed = out_data_reg;

    // Correction of one row at the folded angle, times 900
    function automatic logic signed [CORR_W-1:0] row_corr(
        input logic [ROW_W-1:0] r,
        input logic             seg,
        input logic [X_W-1:0]   x
    );
        logic signed [PROD_W-1:0]  base;
        logic signed [SLOPE_W-1:0] slope;
        logic signed [PROD_W-1:0]  prod;
        logic signed [PROD_W-1:0]  total;
        if (seg)
        begin
            base  = PROD_W'(ROW_C90[r]) * PROD_W'(ANG_QUART);
            slope = SLOPE_W'(ROW_C180[r]) - SLOPE_W'(ROW_C90[r]);
        end
        else
        begin
            base  = PROD_W'(ROW_C0[r]) * PROD_W'(ANG_QUART);
            slope = SLOPE_W'(ROW_C90[r]) - SLOPE_W'(ROW_C0[r]);
        end
        prod  = PROD_W'(slope) * PROD_W'($signed({1'b0, x}));
        total = base + prod;
        return total[CORR_W-1:0];
    endfunction

    // Stage 1 logic
    always_comb
    begin
        lo_idx = (head.data.hi == '0) ? '0 : head.data.hi - 1'b1;
        seg_hi = head.data.ang > FANG_W'(ANG_QUART);
        if (seg_hi)
            seg_x = X_W'(head.data.ang - FANG_W'(ANG_QUART));
        else
            seg_x = head.data.ang[X_W-1:0];
        cl_next = row_corr(lo_idx, seg_hi, seg_x);
        ch_next = row_corr(head.data.hi, seg_hi, seg_x);
        // zero speed: single row, unit spacing, no offset
        if (head.data.hi == '0)
        begin
            ds_next  = SPD_W'(1);
            ofs_next = '0;
        end
        else
        begin
            ds_next  = ROW_SPEED[head.data.hi] - ROW_SPEED[lo_idx];
            ofs_next = head.data.raw - {ROW_SPEED[lo_idx], 4'b0000};
        end
    end

    // Stage 2 logic
    always_comb
    begin
        logic signed [DC_W-1:0] dc;
        dc       = DC_W'(s1_ch_reg) - DC_W'(s1_cl_reg);
        p1_next  = P1_W'(s1_cl_reg) * P1_W'($signed({1'b0, s1_ds_reg}));
        c2_next  = C2_W'(dc) * C2_W'($signed({1'b0, s1_ofs_reg}));
        dvs_next = DVS_W'(s1_ds_reg) * DVS_W'(DVS_STEP);
        k_next   = K_W'(s1_ds_reg) * K_W'(BIAS_STEP);
    end

    // Stage 3 logic: 2*(16*cl*ds + dc*offset) + den*(2^DIV_BITS + 1)
    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        sum = (SUM_W'(s2_p1_reg) <<< 5) + (SUM_W'(s2_c2_reg) <<< 1)
            + $signed({{(SUM_W - K_W){1'b0}}, s2_k_reg});
        rem_next = sum[REM_W-1:0];
    end

    // Restoring division steps, most significant quotient bit first
    always_comb
    begin
        for (int s = 0; s < DIV_BITS; s++)
        begin
            logic [REM_W-1:0]    rem_in;
            logic [DVS_W-1:0]    dvs_in;
            logic [DIV_BITS-1:0] quo_in;
            logic [REM_W-1:0]    trial;
            if (s == 0)
            begin
                rem_in = s3_rem_reg;
                dvs_in = s3_dvs_reg;
                quo_in = '0;
            end
            else
            begin
                rem_in = dv_rem_reg[s-1];
                dvs_in = dv_dvs_reg[s-1];
                quo_in = dv_quo_reg[s-1];
            end
            trial = REM_W'(dvs_in) << (DIV_BITS - 1 - s);
            dv_rem_next[s] = rem_in;
            dv_quo_next[s] = quo_in;
            if (rem_in >= trial)
            begin
                dv_rem_next[s] = rem_in - trial;
                dv_quo_next[s][DIV_BITS-1-s] = 1'b1;
            end
        end
    end

    // Remove the quotient bias, add to raw speed, saturate
    always_comb
    begin
        logic signed [RES_W-1:0] res;
        res = $signed({3'b000, dv_raw_reg[DIV_BITS-1]})
            + $signed({{(RES_W - DIV_BITS){1'b0}}, dv_quo_reg[DIV_BITS-1]})
            - RES_W'(1 << (DIV_BITS - 1));
        if (res < 0)
            out_data_next = '0;
        else if (res > RES_W'((1 << OUT_W) - 1))
            out_data_next = '1;
        else
            out_data_next = res[OUT_W-1:0];
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            for (int s = 0; s < DIV_BITS; s++)
                dv_v_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= head.valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            dv_v_reg[0] <= s3_v_reg;
            for (int s = 1; s < DIV_BITS; s++)
                dv_v_reg[s] <= dv_v_reg[s-1];
            out_v_reg <= dv_v_reg[DIV_BITS-1];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_raw_reg <= head.data.raw;
            s1_cl_reg  <= cl_next;
            s1_ch_reg  <= ch_next;
            s1_ds_reg  <= ds_next;
            s1_ofs_reg <= ofs_next;

            s2_raw_reg <= s1_raw_reg;
            s2_p1_reg  <= p1_next;
            s2_c2_reg  <= c2_next;
            s2_dvs_reg <= dvs_next;
            s2_k_reg   <= k_next;

            s3_raw_reg <= s2_raw_reg;
            s3_rem_reg <= rem_next;
            s3_dvs_reg <= s2_dvs_reg;

            dv_raw_reg[0] <= s3_raw_reg;
            dv_dvs_reg[0] <= s3_dvs_reg;
            for (int s = 1; s < DIV_BITS; s++)
            begin
                dv_raw_reg[s] <= dv_raw_reg[s-1];
                dv_dvs_reg[s] <= dv_dvs_reg[s-1];
            end
            for (int s = 0; s < DIV_BITS; s++)
            begin
                dv_rem_reg[s] <= dv_rem_next[s];
                dv_quo_reg[s] <= dv_quo_next[s];
            end

            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire
